// File: rtl/klx_pkg.sv
// shared types and constants for the keyword lexer
// token kinds, keyword spelling table, token and bundle records, queue depth
// no dependencies
package klx_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned MAX_TOKS = 3;
	localparam int unsigned NUM_KW = 9;

	localparam logic [4:0] KIND_NUMBER = 5'd0;
	localparam logic [4:0] KIND_IDENT  = 5'd1;
	localparam logic [4:0] KIND_KW0    = 5'd2;
	localparam logic [4:0] KIND_TWO0   = 5'd11;
	localparam logic [4:0] KIND_SINGLE0 = 5'd15;
	localparam logic [4:0] KIND_HELD0  = 5'd25;
	localparam logic [4:0] KIND_END    = 5'd28;
	localparam logic [4:0] KIND_ERROR  = 5'd29;

	// keyword spelling, zero padded to eight characters
	localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
		'{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00},
		'{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "e", "f", "a", "u", "l", "t", 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd2, 3'd4, 3'd5, 3'd2, 3'd6, 3'd4, 3'd7, 3'd6, 3'd5
	};

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  bad;
	} tok_t;

	// all tokens caused by one character word
	typedef struct packed {
		tok_t [MAX_TOKS-1:0] tok;
		logic [1:0]          cnt;
	} bundle_t;

endpackage

// File: rtl/klx_front.sv
// scanner front end: accepts one character word per cycle while acc is high, keeps the scan state
// and builds the bundle of tokens that the character causes
// depends on klx_pkg
module klx_front #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       char_code,
	input  logic             is_last,
	input  logic             no_char,
	output logic             push,
	output klx_pkg::bundle_t bun
);
	import klx_pkg::*;

	localparam int unsigned P = POSITION_BITS;

	typedef enum logic [2:0] {M_IDLE, M_NUM, M_WORD, M_OP, M_DISCARD} mode_t;

	localparam logic [1:0] OP_LT = 2'd0;
	localparam logic [1:0] OP_GT = 2'd1;
	localparam logic [1:0] OP_EQ = 2'd2;
	localparam logic [1:0] OP_BANG = 2'd3;

	mode_t      mode_q, mode_d;
	logic [1:0] pend_q, pend_d;
	logic [P-1:0] start_q, start_d;
	logic [P-1:0] len_q, len_d;
	logic [P-1:0] pos_q, pos_d;
	logic [NUM_KW-1:0] kwm_q, kwm_d;

	function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
		return (&v) ? v : v + P'(1);
	endfunction

	function automatic logic [15:0] low16(input logic [P-1:0] v);
		logic [P+15:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// drop keywords that are no longer than len or whose spelling differs at index len
	function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] m,
			input logic [P-1:0] len, input logic [7:0] c);
		logic [NUM_KW-1:0] r;
		r = m;
		for (int k = 0; k < NUM_KW; k++) begin
			if (!(len < P'(KW_LEN[k])) || (KW_TEXT[k][len[2:0]] != c))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [4:0] word_kind(input logic [NUM_KW-1:0] m,
			input logic [P-1:0] len);
		logic [4:0] r;
		r = KIND_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (m[k] && (len == P'(KW_LEN[k])))
				r = KIND_KW0 + 5'(k);
		end
		return r;
	endfunction

	function automatic tok_t mk_tok(input logic [4:0] kind, input logic [15:0] start,
			input logic [15:0] length, input logic [7:0] bad);
		tok_t t;
		t.kind = kind;
		t.start = start;
		t.length = length;
		t.bad = bad;
		return t;
	endfunction

	// token that ends the pending construct in mode m
	function automatic tok_t flush_tok(input mode_t m, input logic [1:0] pend,
			input logic [P-1:0] start, input logic [P-1:0] len,
			input logic [NUM_KW-1:0] kwm);
		tok_t t;
		case (m)
			M_NUM:   t = mk_tok(KIND_NUMBER, low16(start), low16(len), 8'h00);
			M_WORD:  t = mk_tok(word_kind(kwm, len), low16(start), low16(len), 8'h00);
			M_OP: begin
				if (pend == OP_BANG)
					t = mk_tok(KIND_ERROR, low16(start), 16'd1, "!");
				else
					t = mk_tok(KIND_HELD0 + 5'(pend), low16(start), 16'd1, 8'h00);
			end
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic has_pending(input mode_t m);
		return (m == M_NUM) || (m == M_WORD) || (m == M_OP);
	endfunction

	logic [1:0] n;
	logic       do_start;
	logic       flush_err;
	logic       single_hit;
	logic [4:0] single_kind;

	always_comb begin
		single_hit = 1'b1;
		case (char_code)
			"+": single_kind = KIND_SINGLE0 + 5'd0;
			"-": single_kind = KIND_SINGLE0 + 5'd1;
			"*": single_kind = KIND_SINGLE0 + 5'd2;
			"/": single_kind = KIND_SINGLE0 + 5'd3;
			"(": single_kind = KIND_SINGLE0 + 5'd4;
			")": single_kind = KIND_SINGLE0 + 5'd5;
			"{": single_kind = KIND_SINGLE0 + 5'd6;
			"}": single_kind = KIND_SINGLE0 + 5'd7;
			";": single_kind = KIND_SINGLE0 + 5'd8;
			":": single_kind = KIND_SINGLE0 + 5'd9;
			default: begin
				single_kind = KIND_ERROR;
				single_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		start_d = start_q;
		len_d = len_q;
		pos_d = pos_q;
		kwm_d = kwm_q;
		bun = '0;
		n = 2'd0;
		do_start = 1'b0;
		flush_err = (mode_q == M_OP) && (pend_q == OP_BANG);

		if (!no_char) begin
			pos_d = sat_inc(pos_q);
			case (mode_q)
				M_NUM: begin
					if (is_digit(char_code) || (char_code == ".")) begin
						len_d = sat_inc(len_q);
					end else begin
						bun.tok[n] = flush_tok(mode_q, pend_q, start_q, len_q, kwm_q);
						n = n + 2'd1;
						mode_d = M_IDLE;
						do_start = 1'b1;
					end
				end
				M_WORD: begin
					if (is_alpha(char_code) || is_digit(char_code) || (char_code == "_")) begin
						kwm_d = narrow(kwm_q, len_q, char_code);
						len_d = sat_inc(len_q);
					end else begin
						bun.tok[n] = flush_tok(mode_q, pend_q, start_q, len_q, kwm_q);
						n = n + 2'd1;
						mode_d = M_IDLE;
						do_start = 1'b1;
					end
				end
				M_OP: begin
					if (char_code == "=") begin
						bun.tok[n] = mk_tok(KIND_TWO0 + 5'(pend_q), low16(start_q), 16'd2, 8'h00);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						bun.tok[n] = flush_tok(mode_q, pend_q, start_q, len_q, kwm_q);
						n = n + 2'd1;
						// a lone bang swallows this character
						mode_d = flush_err ? M_DISCARD : M_IDLE;
						do_start = !flush_err;
					end
				end
				M_IDLE: do_start = 1'b1;
				default: ;
			endcase

			if (do_start && !is_space(char_code)) begin
				start_d = pos_q;
				len_d = P'(1);
				if (is_digit(char_code)) begin
					mode_d = M_NUM;
				end else if (is_alpha(char_code) || (char_code == "_")) begin
					kwm_d = narrow('1, '0, char_code);
					mode_d = M_WORD;
				end else if ((char_code == "<") || (char_code == ">") || (char_code == "=")
						|| (char_code == "!")) begin
					pend_d = (char_code == "<") ? OP_LT : (char_code == ">") ? OP_GT :
						(char_code == "=") ? OP_EQ : OP_BANG;
					mode_d = M_OP;
				end else if (single_hit) begin
					bun.tok[n] = mk_tok(single_kind, low16(pos_q), 16'd1, 8'h00);
					n = n + 2'd1;
				end else begin
					bun.tok[n] = mk_tok(KIND_ERROR, low16(pos_q), 16'd1, char_code);
					n = n + 2'd1;
					mode_d = M_DISCARD;
				end
			end
		end

		if (is_last) begin
			if (mode_d != M_DISCARD) begin
				if (has_pending(mode_d)) begin
					bun.tok[n] = flush_tok(mode_d, pend_d, start_d, len_d, kwm_d);
					n = n + 2'd1;
				end
				if (!((mode_d == M_OP) && (pend_d == OP_BANG))) begin
					bun.tok[n] = mk_tok(KIND_END, low16(pos_d), 16'd0, 8'h00);
					n = n + 2'd1;
				end
			end
			mode_d = M_IDLE;
			pend_d = OP_LT;
			start_d = '0;
			len_d = '0;
			pos_d = '0;
			kwm_d = '1;
		end
		bun.cnt = n;
	end

	assign push = acc && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= OP_LT;
			start_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			kwm_q <= '1;
		end else if (acc) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			start_q <= start_d;
			len_q <= len_d;
			pos_q <= pos_d;
			kwm_q <= kwm_d;
		end
	end

endmodule

// File: rtl/klx_queue.sv
// short queue of token bundles between the scanner and the output stage
// depends on klx_pkg
module klx_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  klx_pkg::bundle_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output klx_pkg::bundle_t head
);
	import klx_pkg::*;

	localparam int unsigned AW = $clog2(QDEPTH);

	bundle_t        slot_q [QDEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign full = (cnt_q == (AW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)
				rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/klx_back.sv
// output stage: walks the head bundle one token per cycle into the output register while tok_stall is low
// depends on klx_pkg
module klx_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  klx_pkg::bundle_t head,
	output logic             pop,
	input  logic             tok_stall,
	output logic             tok_valid,
	output klx_pkg::tok_t    tok,
	output logic             tok_last
);
	import klx_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;

	assign load = !empty && (!tok_valid || !tok_stall);
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			tok_valid <= 1'b1;
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (!tok_stall) begin
			tok_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok <= head.tok[idx_q];
			tok_last <= at_end;
		end
	end

endmodule

// File: rtl/keyword_lexer.sv
// keyword lexer top level: scanner front end, bundle queue, output stage
// depends on klx_pkg, klx_front, klx_queue, klx_back
//
// Takes one character word per cycle unless char_stall is high and emits tokens (kind,
// start, length, offending byte, last-of-character flag). The scan state updates in
// the cycle a character is taken, so characters can arrive back to back. One character
// can cause up to three tokens; the output register sends one token per cycle while
// tok_stall is low, so such a character holds the output side until its tokens are
// sent. A four-entry bundle queue between scanner and output absorbs these bursts;
// char_stall rises only while that queue is full. Tokens pass through the bundle queue
// and then the output register. No clearing pass is needed after reset.
module keyword_lexer #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	input  logic        no_char,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [4:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [7:0]  bad_char,
	output logic        run_last
);
	import klx_pkg::*;

	logic    acc, push, pop, full, empty;
	bundle_t bun, head;
	tok_t    tok;

	assign char_stall = full;
	assign acc = char_valid && !full;

	klx_front #(.POSITION_BITS(POSITION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .char_code(char_code),
		.is_last(is_last), .no_char(no_char), .push(push), .bun(bun)
	);

	klx_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(bun), .pop(pop),
		.full(full), .empty(empty), .head(head)
	);

	klx_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.tok_stall(tok_stall), .tok_valid(tok_valid), .tok(tok), .tok_last(run_last)
	);

	assign token_kind = tok.kind;
	assign token_start = tok.start;
	assign token_length = tok.length;
	assign bad_char = tok.bad;

endmodule

// File: rtl/klx_checker.sv
// port-level checks for the keyword lexer, bound to the top level
// depends on klx_pkg and keyword_lexer
module klx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_stall,
	input logic [7:0]  char_code,
	input logic        is_last,
	input logic        no_char,
	input logic        tok_valid,
	input logic        tok_stall,
	input logic [4:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic [7:0]  bad_char,
	input logic        run_last
);
	import klx_pkg::*;

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_code)
			&& $stable(is_last) && $stable(no_char))
		else $error("stalled input word changed");

	// a stalled token holds its kind, start, length and last flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind)
			&& $stable(token_start) && $stable(token_length) && $stable(run_last))
		else $error("stalled token changed");

	// end marker closes its character's tokens and carries no length
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == KIND_END) |-> run_last && (token_length == 16'd0))
		else $error("bad end token");

	// an error ends the string, so nothing follows it for that character
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == KIND_ERROR) |-> run_last && (token_length == 16'd1))
		else $error("bad error token");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind != KIND_ERROR) |-> (bad_char == 8'h00))
		else $error("offending byte on a good token");

endmodule

bind keyword_lexer klx_checker u_klx_checker (.*);
